// File: rtl/core/irpd_pkg.sv
// Package for the IR pause-frame decoder: frame length, register indexes,
// the key code table and the types shared between the decoder modules.
// Depends on nothing.
`timescale 1ns / 1ps

package irpd_pkg;

  // Pauses per frame, leader included (legal range 18 to 32).
  localparam int unsigned FRAME_ENTRIES = 32;
  localparam int unsigned CntW          = $clog2(FRAME_ENTRIES);

  localparam int unsigned PauseW = 16;
  localparam int unsigned CodeW  = 15;
  localparam int unsigned KeyW   = 5;

  // Last entry of the fixed header; data bits follow it.
  localparam int unsigned HDR_SHORT_LAST = 8;
  localparam int unsigned HDR_LONG_LAST  = 16;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SPLIT      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_MAX   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEADER_MIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LEADER_MAX = 3'd4;

  localparam logic [PauseW-1:0] RST_SHORT_MIN  = 16'd200;
  localparam logic [PauseW-1:0] RST_SPLIT      = 16'd1000;
  localparam logic [PauseW-1:0] RST_LONG_MAX   = 16'd2000;
  localparam logic [PauseW-1:0] RST_LEADER_MIN = 16'd4000;
  localparam logic [PauseW-1:0] RST_LEADER_MAX = 16'd5000;

  localparam int unsigned KEY_COUNT = 17;
  localparam logic [KeyW-1:0] KEY_UNKNOWN = 5'd17;

  // Order gives the key index: up, down, left, right, ok, digits 0-9, star, hash.
  localparam logic [CodeW-1:0] KEY_CODES [KEY_COUNT] = '{
    15'd12622, 15'd21547, 15'd4462,  15'd24862, 15'd382,
    15'd9562,  15'd13387, 15'd19507, 15'd22567, 15'd6247,
    15'd3187,  15'd15682, 15'd2167,  15'd7267,  15'd11602,
    15'd8542,  15'd10582
  };

  typedef struct packed {
    logic [PauseW-1:0] short_min;
    logic [PauseW-1:0] split;
    logic [PauseW-1:0] long_max;
    logic [PauseW-1:0] leader_min;
    logic [PauseW-1:0] leader_max;
  } cfg_t;

  // What the frame tracker hands to the result stage.
  typedef struct packed {
    logic             emit;
    logic [CodeW-1:0] code;
  } frame_res_t;

  function automatic logic [KeyW-1:0] key_lookup(input logic [CodeW-1:0] code);
    logic [KeyW-1:0] key;
    key = KEY_UNKNOWN;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (KEY_CODES[i] == code) begin
        key = KeyW'(i);
      end
    end
    return key;
  endfunction

endpackage

// File: rtl/core/irpd_cfg_regs.sv
// Configuration registers of the IR pause-frame decoder: the five window
// bounds, written through the configuration channel. Depends on irpd_pkg.
`timescale 1ns / 1ps

module irpd_cfg_regs import irpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PauseW-1:0]  cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SHORT_MIN:  cfg_d.short_min  = cfg_data_i;
        CFG_SPLIT:      cfg_d.split      = cfg_data_i;
        CFG_LONG_MAX:   cfg_d.long_max   = cfg_data_i;
        CFG_LEADER_MIN: cfg_d.leader_min = cfg_data_i;
        CFG_LEADER_MAX: cfg_d.leader_max = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_min  <= RST_SHORT_MIN;
      cfg_q.split      <= RST_SPLIT;
      cfg_q.long_max   <= RST_LONG_MAX;
      cfg_q.leader_min <= RST_LEADER_MIN;
      cfg_q.leader_max <= RST_LEADER_MAX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/irpd_frame.sv
// Frame tracker of the IR pause-frame decoder: classifies one pause, keeps
// the frame position, the header check and the data shift register.
// Depends on irpd_pkg.
`timescale 1ns / 1ps

module irpd_frame import irpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [PauseW-1:0] pause_i,
  input  cfg_t              cfg_i,
  output frame_res_t        res_o
);

  logic             in_frame_q, in_frame_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             bad_q, bad_d;
  logic [CodeW-1:0] shift_q, shift_d;

  logic is_short, is_long, is_leader, last, bad_now;

  assign is_short  = (pause_i > cfg_i.short_min) && (pause_i < cfg_i.split);
  assign is_long   = (pause_i > cfg_i.split) && (pause_i < cfg_i.long_max);
  assign is_leader = (pause_i > cfg_i.leader_min) && (pause_i < cfg_i.leader_max);
  assign last      = (count_q == CntW'(FRAME_ENTRIES - 1));

  always_comb begin
    bad_now = 1'b0;
    if (count_q <= CntW'(HDR_SHORT_LAST)) begin
      bad_now = !is_short;
    end else if (count_q <= CntW'(HDR_LONG_LAST)) begin
      bad_now = !is_long;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    bad_d      = bad_q;
    shift_d    = shift_q;
    if (step_i) begin
      if (!in_frame_q) begin
        if (is_leader) begin
          in_frame_d = 1'b1;
          count_d    = CntW'(1);
          bad_d      = 1'b0;
          shift_d    = '0;
        end
      end else if (last) begin
        in_frame_d = 1'b0;
        count_d    = '0;
        bad_d      = 1'b0;
        shift_d    = '0;
      end else begin
        count_d = count_q + CntW'(1);
        bad_d   = bad_q | bad_now;
        if (count_q > CntW'(HDR_LONG_LAST)) begin
          // The windows cannot overlap, as both exclude the split; long is checked first.
          if (is_long) begin
            shift_d = {shift_q[CodeW-2:0], 1'b1};
          end else if (is_short) begin
            shift_d = {shift_q[CodeW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      bad_q      <= 1'b0;
      shift_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      bad_q      <= bad_d;
      shift_q    <= shift_d;
    end
  end

  // The last entry always lies in the data part, so it can add a bit.
  always_comb begin
    res_o.emit = in_frame_q && last && !(bad_q || bad_now);
    res_o.code = shift_q;
    if (is_long) begin
      res_o.code = {shift_q[CodeW-2:0], 1'b1};
    end else if (is_short) begin
      res_o.code = {shift_q[CodeW-2:0], 1'b0};
    end
  end

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (count_q == '0))
    else $error("frame position is not zero outside a frame");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (count_q >= CntW'(1)) && (count_q <= CntW'(FRAME_ENTRIES - 1)))
    else $error("frame position out of range");

  a_close_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.emit) |=> !in_frame_q && !bad_q && (shift_q == '0))
    else $error("frame not closed after its result");

endmodule

// File: rtl/core/irpd_result.sv
// Result stage of the IR pause-frame decoder: looks up the key index of a
// finished code and holds the result until it is taken. Depends on irpd_pkg.
`timescale 1ns / 1ps

module irpd_result import irpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [CodeW-1:0] code_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [KeyW-1:0]  key_index_o,
  output logic [CodeW-1:0] raw_code_o
);

  logic             vld_q, vld_d;
  logic [KeyW-1:0]  key_q;
  logic [CodeW-1:0] code_q;

  always_comb begin
    vld_d = vld_q;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (load_i) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q  <= key_lookup(code_i);
      code_q <= code_i;
    end
  end

  assign out_valid_o = vld_q;
  assign key_index_o = key_q;
  assign raw_code_o  = code_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !vld_q || out_ready_i)
    else $error("result overwritten before the transaction completed");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> key_q <= KEY_UNKNOWN)
    else $error("key index out of range");

  a_key_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && key_q != KEY_UNKNOWN) |-> (KEY_CODES[key_q] == code_q))
    else $error("key index does not match the raw code");

endmodule

// File: rtl/core/ir_pause_frame_decoder.sv
// Top level of the IR pause-frame decoder: input register, configuration
// registers, frame tracker and result stage. Depends on irpd_pkg.
//
// Usage: pause lengths enter on the input channel (in_valid_i/in_ready_o,
// pause_length_i), one transaction per pause. A pause inside the leader
// window opens a frame; after the full frame of 32 pauses a frame with a
// good header yields one transaction on the output channel
// (out_valid_o/out_ready_i) carrying the raw code and its key index.
// Bad frames and stray pauses yield nothing.
// The window bounds are written on the configuration channel (cfg_valid_i,
// cfg_index_i, cfg_data_i); cfg_ready_o is always high and indexes past the
// last register are ignored. Write them only while the decoder is idle.
// A pause is held in the input register and decoded from there; the result of
// its last pause is registered in the result stage, which drives out_valid_o.
// Throughput: one pause per cycle unless the output stalls, set by the single
// input register before one compare stage. A stalled output only holds back
// a pause that would produce a new result; all other pauses keep flowing.
// Reset puts the bounds to their defaults and closes any open frame.
`timescale 1ns / 1ps

module ir_pause_frame_decoder import irpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PauseW-1:0]  pause_length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [KeyW-1:0]    key_index_o,
  output logic [CodeW-1:0]   raw_code_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PauseW-1:0]  cfg_data_i
);

  cfg_t              cfg;
  frame_res_t        res;
  logic              in_vld_q, in_vld_d;
  logic [PauseW-1:0] pause_q;
  logic              step;
  logic              out_free;

  assign cfg_ready_o = 1'b1;

  irpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !out_valid_o || out_ready_i;
  assign step       = in_vld_q && (!res.emit || out_free);
  assign in_ready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (step) begin
      in_vld_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pause_q <= pause_length_i;
    end
  end

  irpd_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .pause_i (pause_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  irpd_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res.emit),
    .code_i      (res.code),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .key_index_o (key_index_o),
    .raw_code_o  (raw_code_o)
  );

  a_held_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |=> in_vld_q && $stable(pause_q))
    else $error("buffered pause lost while held back");

  a_stall_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |-> res.emit && out_valid_o && !out_ready_i)
    else $error("pause held back without a pending result");

  a_result_follows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.emit) |=> out_valid_o)
    else $error("decoded result did not reach the output");

endmodule
